// ===== rtl/catmull_rom_curve_sampler_defines.svh =====
// Assertion macros for the Catmull-Rom curve sampler
`ifndef CATMULL_ROM_CURVE_SAMPLER_DEFINES_SVH
`define CATMULL_ROM_CURVE_SAMPLER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define CRCS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define CRCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/crcs_pkg.sv =====
// Shared types and constants of the Catmull-Rom curve sampler
`default_nettype none
package crcs_pkg;

  localparam int TICK_W = 24;
  localparam int VAL_W  = 32;
  localparam int IDX_W  = 6;
  localparam int CNT_W  = 7;

  // per-cycle datapath operation
  typedef enum logic [3:0] {
    DP_IDLE,
    DP_FIRST,
    DP_SHIFT,
    DP_MATCH,
    DP_P4,
    DP_DIV,
    DP_MUL_T2,
    DP_MUL_T3,
    DP_HCALC,
    DP_MAC,
    DP_RESULT
  } dp_op_t;

  // table read address source
  typedef enum logic [1:0] {
    ADDR_ZERO,
    ADDR_LAST,
    ADDR_K,
    ADDR_NEXT
  } addr_sel_t;

  // which value the result register takes
  typedef enum logic [1:0] {
    RES_ZERO,
    RES_RD,
    RES_P3,
    RES_CUBIC
  } res_kind_t;

  typedef struct packed {
    logic      accept;
    dp_op_t    op;
    logic      rd_en;
    addr_sel_t rd_sel;
    res_kind_t res_kind;
    logic [1:0] mac_idx;
    logic      acc_clr;
  } ctl_cmd_t;

  typedef struct packed {
    logic n_zero;
    logic n_one;
    logic ge_tick;
    logic le_tick;
    logic num_ge_d;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== rtl/crcs_ctrl.sv =====
// Sequencing state machine of the Catmull-Rom curve sampler
`default_nettype none
module crcs_ctrl import crcs_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire logic     in_kind,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire dp_stat_t stat,
  output ctl_cmd_t      cmd
);

  localparam int CW = $clog2(FRAC_BITS);

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_FIRST, S_LAST, S_SRCH, S_P4, S_DIV,
    S_MT2, S_MT3, S_HC, S_MAC, S_RES
  } state_t;

  state_t    state_r;
  logic      out_valid_r;
  res_kind_t res_kind_r;
  logic [CW-1:0] cnt_r;

  logic out_free;
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // command decode
  always_comb begin
    cmd          = '0;
    cmd.op       = DP_IDLE;
    cmd.rd_sel   = ADDR_ZERO;
    cmd.res_kind = res_kind_r;
    cmd.mac_idx  = cnt_r[1:0];
    cmd.acc_clr  = (cnt_r == '0);
    case (state_r)
      S_IDLE:  cmd.accept = in_valid;
      S_START: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = ADDR_ZERO;
      end
      S_FIRST: begin
        cmd.op     = DP_FIRST;
        // first value stays in the read register when it is the answer
        cmd.rd_en  = !(stat.n_one || stat.ge_tick);
        cmd.rd_sel = ADDR_LAST;
      end
      S_LAST: begin
        // last value stays in the read register when it is the answer
        cmd.rd_en  = !stat.le_tick;
        cmd.rd_sel = ADDR_K;
      end
      S_SRCH: begin
        cmd.op     = stat.ge_tick ? DP_MATCH : DP_SHIFT;
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = ADDR_NEXT;
      end
      S_P4:    cmd.op = DP_P4;
      S_DIV:   cmd.op = DP_DIV;
      S_MT2:   cmd.op = DP_MUL_T2;
      S_MT3:   cmd.op = DP_MUL_T3;
      S_HC:    cmd.op = DP_HCALC;
      S_MAC:   cmd.op = DP_MAC;
      S_RES:   cmd.op = out_free ? DP_RESULT : DP_IDLE;
      default: cmd.op = DP_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      res_kind_r  <= RES_ZERO;
      cnt_r       <= '0;
    end else begin
      if (out_valid_r && out_ready && (state_r != S_RES)) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid && in_kind) state_r <= S_START;
        end
        S_START: begin
          if (stat.n_zero) begin
            res_kind_r <= RES_ZERO;
            state_r    <= S_RES;
          end else begin
            state_r <= S_FIRST;
          end
        end
        S_FIRST: begin
          if (stat.n_one || stat.ge_tick) begin
            res_kind_r <= RES_RD;
            state_r    <= S_RES;
          end else begin
            state_r <= S_LAST;
          end
        end
        S_LAST: begin
          if (stat.le_tick) begin
            res_kind_r <= RES_RD;
            state_r    <= S_RES;
          end else begin
            state_r <= S_SRCH;
          end
        end
        S_SRCH: begin
          if (stat.ge_tick) state_r <= S_P4;
        end
        S_P4: begin
          cnt_r <= '0;
          if (stat.num_ge_d) begin
            res_kind_r <= RES_P3;
            state_r    <= S_RES;
          end else begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (cnt_r == CW'(FRAC_BITS - 1)) begin
            cnt_r   <= '0;
            state_r <= S_MT2;
          end else begin
            cnt_r <= cnt_r + CW'(1);
          end
        end
        S_MT2: state_r <= S_MT3;
        S_MT3: state_r <= S_HC;
        S_HC: begin
          cnt_r   <= '0;
          state_r <= S_MAC;
        end
        S_MAC: begin
          // four products, then the last accumulate
          if (cnt_r == CW'(4)) begin
            res_kind_r <= RES_CUBIC;
            state_r    <= S_RES;
          end else begin
            cnt_r <= cnt_r + CW'(1);
          end
        end
        S_RES: begin
          // out_free here means the output register is empty or being taken
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/crcs_datapath.sv =====
// Point table, segment registers, divider and cubic datapath
`default_nettype none
module crcs_datapath import crcs_pkg::*; #(
  parameter int MAX_POINTS = 64,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_wr_en,
  input  wire logic [CNT_W-1:0]        cfg_wr_data,
  input  wire logic                    in_kind,
  input  wire logic [IDX_W-1:0]        in_point_index,
  input  wire logic [TICK_W-1:0]       in_tick,
  input  wire logic signed [VAL_W-1:0] in_point_value,
  input  wire ctl_cmd_t                cmd,
  output dp_stat_t                     stat,
  output logic signed [VAL_W-1:0]      out_curve_value,
  output logic                         out_saturated
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int NW = $clog2(MAX_POINTS + 1);
  localparam int F  = FRAC_BITS;
  localparam int MA = F + 4;
  localparam int MB = VAL_W + 2;
  localparam int PW = MA + MB;
  localparam int SW = PW + 2;

  // point table
  logic [TICK_W-1:0] ticks_mem [MAX_POINTS];
  logic [VAL_W-1:0]  vals_mem  [MAX_POINTS];
  logic [TICK_W-1:0] rd_tick_r;
  logic signed [VAL_W-1:0] rd_val_r;

  logic [CNT_W-1:0]  count_r;
  logic [TICK_W-1:0] tick_r, t_prev_r, t_i_r, d_r, rem_r;
  logic signed [VAL_W-1:0] p1_r, p2_r, p3_r, p4_r;
  logic [AW-1:0] k_r;
  logic [F-1:0]  q_r, t2_r;
  logic signed [MA-1:0] h1x2_r, h2x2_r, h3_r, h4_r;
  logic signed [PW-1:0] prod_r;
  logic signed [SW-1:0] acc_r;
  logic signed [VAL_W-1:0] res_val_r;
  logic res_sat_r;

  // effective point count
  logic [31:0] cnt32, n32, k1_32, last32;
  logic [NW-1:0] n;
  logic [AW-1:0] rd_addr;
  assign cnt32  = 32'(count_r);
  assign n32    = (cnt32 > 32'(MAX_POINTS)) ? 32'(MAX_POINTS) : cnt32;
  assign n      = NW'(n32);
  assign k1_32  = 32'(k_r) + 32'd1;
  assign last32 = 32'(n) - 32'd1;

  always_comb begin
    case (cmd.rd_sel)
      ADDR_ZERO: rd_addr = '0;
      ADDR_LAST: rd_addr = AW'(last32);
      ADDR_K:    rd_addr = k_r;
      ADDR_NEXT: rd_addr = (k1_32 < last32) ? AW'(k1_32) : AW'(last32);
      default:   rd_addr = '0;
    endcase
  end

  // segment offsets
  logic [TICK_W-1:0] num;
  logic [TICK_W-1:0] d_now;
  assign num   = tick_r - t_prev_r;
  assign d_now = t_i_r - t_prev_r;

  assign stat.n_zero   = (n == '0);
  assign stat.n_one    = (n == NW'(1));
  assign stat.ge_tick  = (rd_tick_r >= tick_r);
  assign stat.le_tick  = (rd_tick_r <= tick_r);
  assign stat.num_ge_d = (num >= d_now);

  // table write and registered read
  logic load_ok;
  assign load_ok = cmd.accept && !in_kind && (32'(in_point_index) < 32'(MAX_POINTS));

  always_ff @(posedge clk) begin
    if (load_ok) begin
      ticks_mem[AW'(in_point_index)] <= in_tick;
      vals_mem[AW'(in_point_index)]  <= in_point_value;
    end
    if (cmd.rd_en) begin
      rd_tick_r <= ticks_mem[rd_addr];
      rd_val_r  <= $signed(vals_mem[rd_addr]);
    end
  end

  // point count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cfg_wr_en) begin
      count_r <= cfg_wr_data;
    end
  end

  // divider step
  logic [TICK_W:0] rem_sh, rem_sub;
  logic rem_ge;
  assign rem_sh  = {rem_r, 1'b0};
  assign rem_sub = rem_sh - {1'b0, d_r};
  assign rem_ge  = (rem_sh >= {1'b0, d_r});

  // shared multiplier operands
  logic signed [MA-1:0] mul_a;
  logic signed [MB-1:0] mul_b;
  logic [F-1:0] prod_hi;
  assign prod_hi = prod_r[2*F-1:F];

  always_comb begin
    mul_a = $signed(MA'(q_r));
    mul_b = $signed(MB'(q_r));
    case (cmd.op)
      DP_MUL_T3: mul_a = $signed(MA'(prod_hi));
      DP_MAC: begin
        case (cmd.mac_idx)
          2'd0: begin
            mul_a = h1x2_r;
            mul_b = MB'(p2_r);
          end
          2'd1: begin
            mul_a = h2x2_r;
            mul_b = MB'(p3_r);
          end
          2'd2: begin
            mul_a = h3_r;
            mul_b = MB'(p3_r) - MB'(p1_r);
          end
          default: begin
            mul_a = h4_r;
            mul_b = MB'(p4_r) - MB'(p2_r);
          end
        endcase
      end
      default: mul_a = $signed(MA'(q_r));
    endcase
  end

  // Hermite weights
  logic signed [MA-1:0] s1, s2, s3, one_s, h1, h2;
  assign s1    = $signed(MA'(q_r));
  assign s2    = $signed(MA'(t2_r));
  assign s3    = $signed(MA'(prod_hi));
  assign one_s = $signed({{(MA-F-1){1'b0}}, 1'b1, {F{1'b0}}});
  assign h1    = (s3 <<< 1) - (s2 + (s2 <<< 1)) + one_s;
  assign h2    = (s2 + (s2 <<< 1)) - (s3 <<< 1);

  // round half up and clamp
  logic signed [SW-1:0] rsum, rshift, max_s, min_s;
  assign rsum   = acc_r + $signed({{(SW-F-1){1'b0}}, 1'b1, {F{1'b0}}});
  assign rshift = rsum >>> (F + 1);
  assign max_s  = SW'($signed(32'h7fffffff));
  assign min_s  = SW'($signed(32'h80000000));

  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_FIRST: begin
        t_prev_r <= rd_tick_r;
        p1_r     <= rd_val_r;
        p2_r     <= rd_val_r;
        k_r      <= AW'(1);
      end
      DP_SHIFT: begin
        t_prev_r <= rd_tick_r;
        p1_r     <= p2_r;
        p2_r     <= rd_val_r;
        k_r      <= k_r + AW'(1);
      end
      DP_MATCH: begin
        t_i_r <= rd_tick_r;
        p3_r  <= rd_val_r;
      end
      DP_P4: begin
        p4_r  <= rd_val_r;
        rem_r <= num;
        d_r   <= d_now;
        q_r   <= '0;
      end
      DP_DIV: begin
        rem_r <= rem_ge ? rem_sub[TICK_W-1:0] : rem_sh[TICK_W-1:0];
        q_r   <= {q_r[F-2:0], rem_ge};
      end
      DP_MUL_T2: prod_r <= mul_a * mul_b;
      DP_MUL_T3: begin
        t2_r   <= prod_hi;
        prod_r <= mul_a * mul_b;
      end
      DP_HCALC: begin
        h1x2_r <= h1 <<< 1;
        h2x2_r <= h2 <<< 1;
        h3_r   <= s3 - (s2 <<< 1) + s1;
        h4_r   <= s3 - s2;
      end
      DP_MAC: begin
        prod_r <= mul_a * mul_b;
        acc_r  <= cmd.acc_clr ? '0 : acc_r + SW'(prod_r);
      end
      DP_RESULT: begin
        res_sat_r <= 1'b0;
        case (cmd.res_kind)
          RES_ZERO: res_val_r <= '0;
          RES_RD:   res_val_r <= rd_val_r;
          RES_P3:   res_val_r <= p3_r;
          default: begin
            if (rshift > max_s) begin
              res_val_r <= VAL_W'(max_s);
              res_sat_r <= 1'b1;
            end else if (rshift < min_s) begin
              res_val_r <= VAL_W'(min_s);
              res_sat_r <= 1'b1;
            end else begin
              res_val_r <= VAL_W'(rshift);
            end
          end
        endcase
      end
      default: ;
    endcase
    if (cmd.accept) tick_r <= in_tick;
  end

  assign out_curve_value = res_val_r;
  assign out_saturated   = res_sat_r;

endmodule
`default_nettype wire

// ===== rtl/catmull_rom_curve_sampler.sv =====
// Top level of the Catmull-Rom curve sampler
//
// Input channel (in_*): valid/ready. kind 0 writes point_index with a tick
// and a Q16.16 value and gives no result; kind 1 queries the curve at tick
// and gives one result (curve_value, saturated) on the out_* channel.
// cfg_wr_en/cfg_wr_data set the point count; write it only while idle.
// A load is written into the table as it is accepted. A query for an empty
// table or at an end point is answered without a search; otherwise it walks
// the table one point per cycle up to the segment (one table read port),
// then the restoring divider gives FRAC_BITS quotient bits of t, and the
// shared multiplier forms t^2, t^3 and the four Hermite products in turn.
// The result sits in an output register; a new item is taken while it
// waits, and a later query holds in its final step until the receiver
// takes the earlier result.
// Reset clears the point count, the controller and out_valid; the table
// keeps its contents and must be loaded before it is read.
`default_nettype none
`include "catmull_rom_curve_sampler_defines.svh"
module catmull_rom_curve_sampler import crcs_pkg::*; #(
  parameter int MAX_POINTS = 64,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_wr_en,
  input  wire logic [CNT_W-1:0]        cfg_wr_data,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic                    in_kind,
  input  wire logic [IDX_W-1:0]        in_point_index,
  input  wire logic [TICK_W-1:0]       in_tick,
  input  wire logic signed [VAL_W-1:0] in_point_value,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic signed [VAL_W-1:0]      out_curve_value,
  output logic                         out_saturated
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  crcs_ctrl #(.FRAC_BITS(FRAC_BITS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_kind),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  crcs_datapath #(.MAX_POINTS(MAX_POINTS), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_kind         (in_kind),
    .in_point_index  (in_point_index),
    .in_tick         (in_tick),
    .in_point_value  (in_point_value),
    .cmd             (cmd),
    .stat            (stat),
    .out_curve_value (out_curve_value),
    .out_saturated   (out_saturated)
  );

  // a load item never raises a result
  `CRCS_ASSERT_NEXT(a_load_no_result, in_valid && in_ready && !in_kind && !out_valid, !out_valid, "load item produced a result")
  // a query keeps the block busy in the next cycle
  `CRCS_ASSERT_NEXT(a_query_busy, in_valid && in_ready && in_kind, !in_ready, "query accepted without going busy")
  // a clamped result is at one end of the range
  `CRCS_ASSERT_NOW(a_sat_extreme, out_valid && out_saturated, out_curve_value == 32'sh7fffffff || out_curve_value == $signed(32'h80000000), "saturated result not at range end")

endmodule
`default_nettype wire

// ===== tb/catmull_rom_curve_sampler_tb.sv =====
// Self-checking testbench for the Catmull-Rom curve sampler
`timescale 1ns / 1ps
module catmull_rom_curve_sampler_tb;
  import crcs_pkg::*;

  localparam int PTS       = 64;
  localparam int FB        = 16;
  localparam int STALL_MAX = 5000;
  localparam int DRAIN     = 150;
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;
  localparam logic signed [VAL_W-1:0] VMAX = 32'sh7fffffff;
  localparam logic signed [VAL_W-1:0] VMIN = 32'sh80000000;

  typedef struct {
    logic signed [VAL_W-1:0] curve;
    logic                    sat;
  } sample_t;

  // curve predictor and store of expected samples
  class curve_scoreboard;
    logic [TICK_W-1:0]       ticks[PTS];
    logic signed [VAL_W-1:0] vals[PTS];
    logic [CNT_W-1:0]        count;
    sample_t                 pending_q[$];
    int                      errors;
    int                      queries;
    int                      saturations;

    function new();
      count  = '0;
      errors = 0;
      foreach (ticks[k]) begin
        ticks[k] = '0;
        vals[k]  = '0;
      end
    endfunction

    function void report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endfunction

    function sample_t sample_at(logic [TICK_W-1:0] tick);
      sample_t r;
      int n, i;
      longint num, d, t, t2, t3, h1, h2, h3, h4, p1, p2, p3, p4, s, v;
      n = (count > PTS) ? PTS : count;
      r.sat = 1'b0;
      r.curve = '0;
      if (n == 0) return r;
      if (n == 1 || ticks[0] >= tick) begin
        r.curve = vals[0];
        return r;
      end
      if (ticks[n-1] <= tick) begin
        r.curve = vals[n-1];
        return r;
      end
      i = n - 1;
      for (int k = 1; k < n; k++) begin
        if (ticks[k] >= tick) begin
          i = k;
          break;
        end
      end
      num = longint'(tick) - longint'(ticks[i-1]);
      d   = longint'(ticks[i]) - longint'(ticks[i-1]);
      if (num >= d) begin
        r.curve = vals[i];
        return r;
      end
      t  = (num << FB) / d;
      t2 = (t * t) >>> FB;
      t3 = (t2 * t) >>> FB;
      h1 = 2 * t3 - 3 * t2 + (longint'(1) << FB);
      h2 = 3 * t2 - 2 * t3;
      h3 = t3 - 2 * t2 + t;
      h4 = t3 - t2;
      p1 = vals[(i >= 2) ? i - 2 : 0];
      p2 = vals[i-1];
      p3 = vals[i];
      p4 = vals[(i + 1 < n) ? i + 1 : n - 1];
      s  = 2 * h1 * p2 + 2 * h2 * p3 + h3 * (p3 - p1) + h4 * (p4 - p2);
      v  = (s + (longint'(1) << FB)) >>> (FB + 1);
      if (v > 64'sd2147483647) begin
        v = 64'sd2147483647;
        r.sat = 1'b1;
      end
      if (v < -64'sd2147483648) begin
        v = -64'sd2147483648;
        r.sat = 1'b1;
      end
      r.curve = v[31:0];
      return r;
    endfunction

    // accepted input item: update table or queue the expected sample
    function void note_item(logic kind, logic [IDX_W-1:0] idx, logic [TICK_W-1:0] tick,
                            logic signed [VAL_W-1:0] val);
      sample_t e;
      if (kind == KIND_LOAD) begin
        ticks[idx] = tick;
        vals[idx]  = val;
      end else begin
        e = sample_at(tick);
        pending_q.push_back(e);
        queries++;
        if (e.sat) saturations++;
      end
    endfunction

    // accepted result item: compare with the oldest expectation
    function void check_sample(logic signed [VAL_W-1:0] curve, logic sat);
      sample_t e;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected result curve=%h sat=%b", curve, sat));
        return;
      end
      e = pending_q.pop_front();
      if (curve !== e.curve)
        report($sformatf("curve_value got %h want %h", curve, e.curve));
      if (sat !== e.sat)
        report($sformatf("saturated got %b want %b", sat, e.sat));
    endfunction
  endclass

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_wr_en;
  logic [CNT_W-1:0]        cfg_wr_data;
  logic                    in_valid;
  logic                    in_ready;
  logic                    in_kind;
  logic [IDX_W-1:0]        in_point_index;
  logic [TICK_W-1:0]       in_tick;
  logic signed [VAL_W-1:0] in_point_value;
  logic                    out_valid;
  logic                    out_ready;
  logic signed [VAL_W-1:0] out_curve_value;
  logic                    out_saturated;

  curve_scoreboard sb;
  bit  quiet;
  int  stall_cycles;
  int  items_sent;
  logic [TICK_W-1:0] loaded_ticks[PTS];

  catmull_rom_curve_sampler dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_point_index  (in_point_index),
    .in_tick         (in_tick),
    .in_point_value  (in_point_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_curve_value (out_curve_value),
    .out_saturated   (out_saturated)
  );

  always #2 clk = ~clk;

  // monitor both channels at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_sample(out_curve_value, out_saturated);
      if (in_valid && in_ready)
        sb.note_item(in_kind, in_point_index, in_tick, in_point_value);
    end
  end

  // watchdog on cycles with no item moving
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_MAX) begin
        $display("watchdog: no item moved for %0d cycles", STALL_MAX);
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // receiver with random stall bursts
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk);
      end
      out_ready = 1'b1;
    end
  end

  // present one item at a falling edge and hold it until accepted
  task automatic send(logic kind, logic [IDX_W-1:0] idx, logic [TICK_W-1:0] tick,
                      logic signed [VAL_W-1:0] val);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_kind        = kind;
    in_point_index = idx;
    in_tick        = tick;
    in_point_value = val;
    in_valid       = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic load(int idx, logic [TICK_W-1:0] tick, logic signed [VAL_W-1:0] val);
    send(KIND_LOAD, idx[IDX_W-1:0], tick, val);
    if (idx < PTS) loaded_ticks[idx] = tick;
  endtask

  task automatic query(logic [TICK_W-1:0] tick);
    send(KIND_QUERY, IDX_W'($urandom), tick, $urandom);
  endtask

  // point count is written only once the block has gone quiet
  task automatic set_count(logic [CNT_W-1:0] cnt);
    in_valid = 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (120) @(negedge clk);
    cfg_wr_data = cnt;
    cfg_wr_en   = 1'b1;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    sb.count    = cnt;
  endtask

  function automatic logic signed [VAL_W-1:0] rand_value();
    case ($urandom_range(0, 3))
      0:       return VAL_W'($urandom_range(0, 2 << FB)) - (1 << FB);
      1:       return $urandom_range(0, 1) ? VMAX : VMIN;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int n, pc, step, nq, hi;
    logic [TICK_W-1:0] tk, lo_t, hi_t;
    bit shuffled;

    sb = new();
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_kind = KIND_LOAD;
    in_point_index = '0;
    in_tick = '0;
    in_point_value = '0;
    quiet = 1'b0;
    stall_cycles = 0;
    items_sent = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty table answers zero
    query('0);
    query('1);
    load(63, 24'hffffff, VMIN);
    query(24'h000100);

    // single point returns its value anywhere
    set_count(1);
    load(0, 24'h000100, VMAX);
    query('0);
    query('1);

    // four points: ends, exact point ticks, interior, clamps both ways
    set_count(4);
    load(0, 24'h010000, VMIN);
    load(1, 24'h020000, VMAX);
    load(2, 24'h030000, VMAX);
    load(3, 24'h040000, VMIN);
    query(24'h000000);
    query(24'h010000);
    query(24'h018000);
    query(24'h020000);
    query(24'h028000);
    query(24'h030000);
    query(24'h03ffff);
    query(24'h040000);
    query(24'hffffff);
    load(1, 24'h020000, VMIN);
    load(2, 24'h030000, VMIN);
    load(0, 24'h010000, VMAX);
    load(3, 24'h040000, VMAX);
    query(24'h028000);
    query(24'h020001);

    // random phases over point counts, extremes included
    while (items_sent < 1200) begin
      case ($urandom_range(0, 5))
        0:       pc = 127;
        1:       pc = 64;
        2:       pc = 2;
        3:       pc = 0;
        default: pc = $urandom_range(1, 127);
      endcase
      n = (pc > PTS) ? PTS : pc;
      shuffled = ($urandom_range(0, 6) == 0);
      set_count(pc[CNT_W-1:0]);
      tk = $urandom_range(0, 1000);
      step = (1 << TICK_W) / (n + 1) - 1;
      for (int k = 0; k < n; k++) begin
        load(k, shuffled ? TICK_W'($urandom) : tk, rand_value());
        tk = tk + TICK_W'(($urandom_range(0, 7) == 0) ? 1 : $urandom_range(1, step));
      end
      if (items_sent >= 1000) quiet = 1'b1;
      nq = (n > 16) ? 40 : 25;
      for (int q = 0; q < nq; q++) begin
        if ($urandom_range(0, 9) == 0) begin
          hi = (n > 0) ? n - 1 : 0;
          if ($urandom_range(0, 2) == 0)
            load($urandom_range(0, 63), TICK_W'($urandom), rand_value());
          else
            load($urandom_range(0, hi), loaded_ticks[$urandom_range(0, hi)], rand_value());
        end else if (n == 0 || $urandom_range(0, 7) == 0) begin
          query(TICK_W'($urandom));
        end else if ($urandom_range(0, 4) == 0) begin
          query(loaded_ticks[$urandom_range(0, n - 1)]);
        end else begin
          lo_t = loaded_ticks[0];
          hi_t = loaded_ticks[n-1];
          if (lo_t > hi_t) query(TICK_W'($urandom));
          else query(TICK_W'($urandom_range(lo_t, hi_t)));
        end
      end
    end

    // drain and settle
    in_valid = 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
    if (sb.pending_q.size() != 0)
      sb.report($sformatf("%0d expected results never arrived", sb.pending_q.size()));

    $display("covered %0d items, %0d curve queries, %0d of them clamped",
             items_sent, sb.queries, sb.saturations);
    $display("point counts from empty to over-full, sorted and shuffled tables");
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
